@@ rtl/cic_decimator_top_assert.svh @@
// ----------------------------------------------------------------------------
// CIC decimator assertion macros
// Concurrent checks on the queue between the integrator and comb sections.
// ----------------------------------------------------------------------------
`ifndef CIC_DECIMATOR_TOP_ASSERT_SVH
`define CIC_DECIMATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CICD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CICD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CICD_ASSERT_IMPLY(label, ante, cons, msg)
`define CICD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/cicd_pkg.sv @@
// ----------------------------------------------------------------------------
// CIC decimator package
// Shared widths, limits, register indexes and the queue status type.
// ----------------------------------------------------------------------------
package cicd_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int NUM_STAGES_DEF = 4;
    localparam int ACC_BITS_DEF   = 64;

    localparam int FACTOR_W   = 11;
    localparam int PHASE_W    = 10;
    localparam int GAIN_W     = 32;
    localparam int FACTOR_MAX = 1024;

    localparam int FIFO_DEPTH = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = {1'b1, {(GAIN_W-1){1'b0}}};

    typedef enum logic [0:0] {
        REG_FACTOR = 1'b0,
        REG_GAIN   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

@@ rtl/cicd_if.sv @@
// ----------------------------------------------------------------------------
// CIC decimator stream interfaces
// Valid/ready channels for input samples and decimated output samples.
// ----------------------------------------------------------------------------
interface cicd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cicd_pkg::SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface cicd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cicd_pkg::SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/cic_decimator_top.sv @@
// ----------------------------------------------------------------------------
// CIC decimator top level
// Path: integrators, queue, combs, magnitude, gain product, output register.
// Throughput: one sample per cycle (one-add stages) while the queue has room.
// Reset: clears integrators, comb delays and phase; factor 1, gain unity (Q1.31).
// ----------------------------------------------------------------------------
`include "cic_decimator_top_assert.svh"

module cic_decimator_top #(
    parameter int NUM_STAGES = cicd_pkg::NUM_STAGES_DEF,
    parameter int ACC_BITS   = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cicd_in_if.sink                           in_ch,
    cicd_out_if.source                        out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cicd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cicd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cicd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import cicd_pkg::*;

    logic [FACTOR_W-1:0] factor_reg;
    logic [GAIN_W-1:0]   gain_reg;
    reg_idx_t            reg_idx;
    logic                cfg_wr;

    logic                push;
    logic [ACC_BITS-1:0] push_data;
    logic                pop;
    logic [ACC_BITS-1:0] pop_data;
    fifo_stat_t          fifo_stat;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_FACTOR: factor_reg <= pwdata[FACTOR_W-1:0];
                REG_GAIN:   gain_reg   <= pwdata[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FACTOR: prdata = APB_DATA_W'(factor_reg);
            REG_GAIN:   prdata = APB_DATA_W'(gain_reg);
            default:    prdata = '0;
        endcase
    end

    cicd_integ #(
        .NUM_STAGES (NUM_STAGES),
        .ACC_BITS   (ACC_BITS)
    ) u_integ (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .factor    (factor_reg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_data (push_data)
    );

    cicd_fifo #(
        .WIDTH (ACC_BITS)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .fifo_stat (fifo_stat)
    );

    cicd_comb #(
        .NUM_STAGES (NUM_STAGES),
        .ACC_BITS   (ACC_BITS)
    ) u_comb (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .fifo_stat (fifo_stat),
        .gain      (gain_reg),
        .pop       (pop),
        .out_ch    (out_ch)
    );

    `CICD_ASSERT_IMPLY(a_no_overflow, push, !fifo_stat.full, "item pushed into full queue")
    `CICD_ASSERT_IMPLY(a_no_underflow, pop, !fifo_stat.empty, "item popped from empty queue")
    `CICD_ASSERT_IMPLY(a_stall_cause, !in_ch.ready, fifo_stat.full, "input held without full queue")
    `CICD_ASSERT_NEXT(a_push_lands, push && !pop, !fifo_stat.empty, "pushed item not held in queue")

endmodule

@@ rtl/cicd_integ.sv @@
// ----------------------------------------------------------------------------
// CIC integrator front end
// Accepts samples, runs the pipelined integrator chain and tags every
// decimation_factor-th item for the comb section.
// ----------------------------------------------------------------------------
module cicd_integ #(
    parameter int NUM_STAGES = cicd_pkg::NUM_STAGES_DEF,
    parameter int ACC_BITS   = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cicd_in_if.sink                         in_ch,
    input  logic [cicd_pkg::FACTOR_W-1:0]   factor,
    input  cicd_pkg::fifo_stat_t            fifo_stat,
    output logic                            push,
    output logic [ACC_BITS-1:0]             push_data
);
    import cicd_pkg::*;

    logic [ACC_BITS-1:0] integ_reg [NUM_STAGES];
    logic                iv_reg    [NUM_STAGES];
    logic                em_reg    [NUM_STAGES];
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [FACTOR_W-1:0] factor_eff;
    logic [FACTOR_W-1:0] phase_inc;
    logic                emit;
    logic                adv;
    logic                acc;
    logic [ACC_BITS-1:0] sample_ext;

    // hold the chain only when a tagged item cannot enter a full queue
    assign adv = !(iv_reg[NUM_STAGES-1] && em_reg[NUM_STAGES-1] && fifo_stat.full);
    assign in_ch.ready = adv;
    assign acc = in_ch.valid && adv;

    assign sample_ext = ACC_BITS'(in_ch.sample_in);

    always_comb
    begin
        if (factor == '0)
            factor_eff = FACTOR_W'(1);
        else if (factor > FACTOR_W'(FACTOR_MAX))
            factor_eff = FACTOR_W'(FACTOR_MAX);
        else
            factor_eff = factor;
    end

    assign phase_inc  = {1'b0, phase_reg} + FACTOR_W'(1);
    assign emit       = (phase_inc >= factor_eff);
    assign phase_next = emit ? '0 : phase_inc[PHASE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                integ_reg[k] <= '0;
                iv_reg[k]    <= 1'b0;
                em_reg[k]    <= 1'b0;
            end
        end
        else if (adv)
        begin
            iv_reg[0] <= acc;
            em_reg[0] <= emit;
            if (acc)
            begin
                phase_reg    <= phase_next;
                integ_reg[0] <= integ_reg[0] + sample_ext;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                iv_reg[k] <= iv_reg[k-1];
                em_reg[k] <= em_reg[k-1];
                if (iv_reg[k-1])
                    integ_reg[k] <= integ_reg[k] + integ_reg[k-1];
            end
        end
    end

    assign push      = adv && iv_reg[NUM_STAGES-1] && em_reg[NUM_STAGES-1];
    assign push_data = integ_reg[NUM_STAGES-1];

endmodule

@@ rtl/cicd_fifo.sv @@
// ----------------------------------------------------------------------------
// CIC decimator queue
// Short first-in first-out buffer between integrator and comb sections.
// ----------------------------------------------------------------------------
module cicd_fifo #(
    parameter int WIDTH = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output cicd_pkg::fifo_stat_t fifo_stat
);
    import cicd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data        = mem_reg[rd_ptr_reg];
    assign fifo_stat.full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign fifo_stat.empty = (count_reg == '0);

endmodule

@@ rtl/cicd_comb.sv @@
// ----------------------------------------------------------------------------
// CIC comb back end
// Pipelined comb differencers, magnitude, split gain multiply and
// saturation into the output register.
// ----------------------------------------------------------------------------
module cicd_comb #(
    parameter int NUM_STAGES = cicd_pkg::NUM_STAGES_DEF,
    parameter int ACC_BITS   = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ACC_BITS-1:0]           pop_data,
    input  cicd_pkg::fifo_stat_t          fifo_stat,
    input  logic [cicd_pkg::GAIN_W-1:0]   gain,
    output logic                          pop,
    cicd_out_if.source                    out_ch
);
    import cicd_pkg::*;

    localparam int Q_W = 34;
    localparam logic [Q_W-1:0] NEG_MAG = Q_W'(1) << (SAMPLE_BITS - 1);

    logic [ACC_BITS-1:0] cval_reg [NUM_STAGES];
    logic [ACC_BITS-1:0] cdly_reg [NUM_STAGES];
    logic                cv_reg   [NUM_STAGES];

    logic                av_reg;
    logic                aneg_reg;
    logic [63:0]         mag_reg;
    logic                mv_reg;
    logic                mneg_reg;
    logic [63:0]         lo_reg;
    logic [63:0]         hi_reg;
    logic                out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;
    logic [SAMPLE_BITS-1:0] out_data_next;

    logic                adv;
    logic signed [ACC_BITS-1:0] comb_last;
    logic signed [63:0]  s_ext;
    logic [63:0]         mag_next;
    logic                big;
    logic                rem;
    logic [Q_W-1:0]      q;
    logic [Q_W-1:0]      qn;

    assign adv = !out_valid_reg || out_ch.ready;
    assign pop = adv && !fifo_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                cv_reg[k]   <= 1'b0;
                cdly_reg[k] <= '0;
            end
            av_reg        <= 1'b0;
            mv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            cv_reg[0] <= pop;
            if (pop)
                cdly_reg[0] <= pop_data;
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                cv_reg[k] <= cv_reg[k-1];
                if (cv_reg[k-1])
                    cdly_reg[k] <= cval_reg[k-1];
            end
            av_reg        <= cv_reg[NUM_STAGES-1];
            mv_reg        <= av_reg;
            out_valid_reg <= mv_reg;
        end
    end

    // differences against the stored previous input of each stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pop)
                cval_reg[0] <= pop_data - cdly_reg[0];
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (cv_reg[k-1])
                    cval_reg[k] <= cval_reg[k-1] - cdly_reg[k];
            end
        end
    end

    assign comb_last = cval_reg[NUM_STAGES-1];
    assign s_ext     = 64'(comb_last);
    assign mag_next  = s_ext[63] ? (64'(0) - unsigned'(s_ext)) : unsigned'(s_ext);

    // split the magnitude into two 32-bit halves for the gain product
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aneg_reg <= s_ext[63];
            mag_reg  <= mag_next;
            mneg_reg <= aneg_reg;
            lo_reg   <= 64'(mag_reg[31:0])  * 64'(gain);
            hi_reg   <= 64'(mag_reg[63:32]) * 64'(gain);
            out_data_reg <= out_data_next;
        end
    end

    assign big = |hi_reg[63:16];
    assign rem = |lo_reg[30:0];
    assign q   = Q_W'({hi_reg[16:0], 1'b0}) + Q_W'(lo_reg[63:31]);
    assign qn  = q + Q_W'(rem);

    // floor toward minus infinity: negative magnitudes round up
    always_comb
    begin
        if (!mneg_reg)
        begin
            if (big || q > Q_W'(SAMPLE_MAX))
                out_data_next = SAMPLE_MAX;
            else
                out_data_next = q[SAMPLE_BITS-1:0];
        end
        else
        begin
            if (big || qn > NEG_MAG)
                out_data_next = SAMPLE_MIN;
            else
                out_data_next = SAMPLE_BITS'(Q_W'(0) - qn);
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_data_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CIC decimator testbench
// Feeds samples through the input stream and loads factor and gain over APB.
// Tracks the integrator, comb and phase state beside the block, and checks
// every decimated output item in order. Covers directed corners, back-pressure
// and randomised register settings.
// ----------------------------------------------------------------------------
module testbench;
    import cicd_pkg::*;

    localparam int ACC_W         = ACC_BITS_DEF;
    localparam int STAGES        = NUM_STAGES_DEF;
    localparam int SETTLE_CYCLES = 2 * STAGES + 3 + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int OUT_MAX       = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int OUT_MIN       = -(2 ** (SAMPLE_BITS - 1));

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    class decimated_scoreboard;
        logic [ACC_W-1:0]    integ_sum [STAGES];
        logic [ACC_W-1:0]    comb_prev [STAGES];
        logic [PHASE_W-1:0]  phase;
        logic [FACTOR_W-1:0] factor;
        logic [GAIN_W-1:0]   gain;
        sample_t             awaited_outputs [$];
        int                  outputs_seen;
        int                  errors;

        function new();
            foreach (integ_sum[i])
            begin
                integ_sum[i] = '0;
                comb_prev[i] = '0;
            end
            phase        = '0;
            factor       = FACTOR_RESET;
            gain         = GAIN_RESET;
            outputs_seen = 0;
            errors       = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_FACTOR: factor = value[FACTOR_W-1:0];
                REG_GAIN:   gain   = value[GAIN_W-1:0];
            endcase
        endfunction

        function void take_sample(sample_t x);
            logic [ACC_W-1:0]         carry;
            logic [ACC_W-1:0]         diff;
            logic [ACC_W-1:0]         held;
            logic [FACTOR_W-1:0]      span;
            logic signed [ACC_W+32:0] scaled;
            carry = ACC_W'(x);
            // ripple the new sample through every integrator in one step
            for (int i = 0; i < STAGES; i++)
            begin
                integ_sum[i] = integ_sum[i] + carry;
                carry        = integ_sum[i];
            end
            span = factor;
            if (span == 0)
                span = 1;
            if (span > FACTOR_MAX)
                span = FACTOR_MAX;
            if (FACTOR_W'(phase) + 1'b1 < span)
            begin
                phase = phase + 1'b1;
                return;
            end
            phase = '0;
            diff  = integ_sum[STAGES-1];
            for (int i = 0; i < STAGES; i++)
            begin
                held         = diff;
                diff         = diff - comb_prev[i];
                comb_prev[i] = held;
            end
            // floor of diff * gain / 2^31, then clamp to the sample range
            scaled = ($signed(diff) * $signed({1'b0, gain})) >>> 31;
            if (scaled > OUT_MAX)
                awaited_outputs.push_back(SAMPLE_MAX);
            else if (scaled < OUT_MIN)
                awaited_outputs.push_back(SAMPLE_MIN);
            else
                awaited_outputs.push_back(scaled[SAMPLE_BITS-1:0]);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_output(sample_t got);
            sample_t want;
            outputs_seen++;
            if (awaited_outputs.size() == 0)
                report($sformatf("output %0d: got %0d with none awaited", outputs_seen, got));
            else
            begin
                want = awaited_outputs.pop_front();
                if (got !== want)
                    report($sformatf("output %0d: sample_out got %0d, want %0d",
                                     outputs_seen, got, want));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cicd_in_if  in_ch ();
    cicd_out_if out_ch ();

    decimated_scoreboard sb = new();

    bit source_idle   = 1'b0;
    bit sink_idle     = 1'b0;
    bit quiet_tail    = 1'b0;
    int hold_requests = 0;
    int sent_items    = 0;

    cic_decimator_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic sample_t corner_sample(int k);
        case (k % 6)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return '1;
            4:       return sample_t'(1);
            default: return SAMPLE_MIN + 1'b1;
        endcase
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0, 1:    return corner_sample($urandom_range(0, 5));
            2:       return sample_t'($urandom_range(0, 8)) - sample_t'(4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // unity gain divided by factor to the power of the stage count
    function automatic logic [GAIN_W-1:0] ideal_gain(int f);
        longint unsigned span;
        longint unsigned denom;
        span  = (f == 0) ? 1 : (f > FACTOR_MAX) ? FACTOR_MAX : f;
        denom = 1;
        repeat (STAGES) denom = denom * span;
        return GAIN_W'((64'd1 << 31) / denom);
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic send_sample(sample_t value);
        if (source_idle && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= value;
        do @(posedge clk); while (!in_ch.ready);
        sent_items++;
    endtask

    // hold the input until every awaited output is back and the pipe is empty
    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [FACTOR_W-1:0] f, logic [GAIN_W-1:0] g, int items);
        write_reg(REG_FACTOR, APB_DATA_W'(f));
        write_reg(REG_GAIN, g);
        source_idle = !quiet_tail && $urandom_range(0, 2) != 0;
        sink_idle   = !quiet_tail && $urandom_range(0, 2) != 0;
        repeat (items) send_sample(pick_sample());
        drain_outputs();
    endtask

    task automatic random_phase();
        logic [FACTOR_W-1:0] f;
        logic [GAIN_W-1:0]   g;
        case ($urandom_range(0, 9))
            0:       f = '0;
            1, 2:    f = 1;
            7, 8:    f = $urandom_range(9, 64);
            9:       f = $urandom_range(65, 300);
            default: f = $urandom_range(2, 8);
        endcase
        case ($urandom_range(0, 7))
            0:       g = '1;
            1:       g = $urandom;
            2:       g = GAIN_RESET;
            3:       g = ideal_gain(f) << $urandom_range(1, 3);
            default: g = ideal_gain(f);
        endcase
        run_phase(f, g, $urandom_range(8, 40));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.take_sample(in_ch.sample_in);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_output(out_ch.sample_out);
    end

    initial
    begin : sink_side
        int burst;
        int hold_left;
        int holds_served;
        burst        = 0;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                out_ch.ready <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        int random_start;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: factor one and unity gain pass each sample through
        for (int k = 0; k < 8; k++)
            send_sample(corner_sample(k));
        drain_outputs();

        // factor zero acts as one; full-scale gain drives the output into saturation
        write_reg(REG_FACTOR, '0);
        write_reg(REG_GAIN, '1);
        for (int k = 0; k < 6; k++)
            send_sample(corner_sample(k));
        drain_outputs();

        write_reg(REG_FACTOR, 3);
        write_reg(REG_GAIN, '0);
        repeat (4) send_sample(pick_sample());
        drain_outputs();

        write_reg(REG_FACTOR, 2);
        write_reg(REG_GAIN, ideal_gain(2));
        for (int k = 0; k < 6; k++)
            send_sample(corner_sample(k));
        drain_outputs();

        // back-pressure: stall the output long enough to fill the block, then
        // pause the input until everything has come out
        write_reg(REG_FACTOR, 1);
        write_reg(REG_GAIN, GAIN_RESET);
        for (int k = 0; k < 80; k++)
        begin
            if (k == 10)
                hold_requests++;
            if (k == 50)
                drain_outputs();
            send_sample(pick_sample());
        end
        drain_outputs();

        // lower the factor below the phase already reached
        run_phase(50, ideal_gain(50), 30);
        run_phase(4, ideal_gain(4), 12);

        // factor beyond the top of the range is clamped, so no period completes here
        run_phase(FACTOR_W'(1025), $urandom_range(1, 4096), 40);

        random_start = sent_items;
        while (sent_items - random_start < RANDOM_ITEMS)
            random_phase();

        quiet_tail = 1'b1;
        repeat (3) random_phase();

        if (sb.awaited_outputs.size() != 0)
            sb.report($sformatf("%0d outputs never arrived", sb.awaited_outputs.size()));
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
